// ===== design/gred_pkg.sv =====
// Package for the gray Roberts-cross edge detector.
// Word types, register indexes, widths and reset values; no dependencies.
package gred_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int HEIGHT_CAP = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W      = 12;
    localparam int THR_W      = 9;
    localparam int THR2_W     = 2 * THR_W;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [CNT_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [CNT_W-1:0]  HEIGHT_RST = 12'd480;
    localparam logic [THR2_W-1:0] THR2_RST   = 18'd400;
    localparam logic [CNT_W-1:0]  DIM_MIN    = 12'd2;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             pad;
    } t_pix;

    typedef struct packed {
        logic edge_res;
        logic frame_end;
    } t_res;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] hi);
        logic [CNT_W-1:0] res;
        res = v;
        if (v < DIM_MIN) res = DIM_MIN;
        if (v > hi) res = hi;
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] to_gray(input t_pix p);
        logic [PIX_W-1:0] m;
        m = p.red;
        if (p.green > m) m = p.green;
        if (p.blue > m) m = p.blue;
        return (m != '0) ? m - PIX_W'(1) : '0;
    endfunction

endpackage

// ===== design/gred_if.sv =====
// Valid/ready channel interfaces for pixel words and result words.
// Depends on gred_pkg for the word types.
interface gred_pix_if;
    logic          valid;
    logic          ready;
    gred_pkg::t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gred_res_if;
    logic          valid;
    logic          ready;
    gred_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/gray_roberts_edge_detect.sv =====
// Gray Roberts-cross edge detector: line memory, gradient pipeline, output register.
// Depends on gred_pkg and the channel interfaces in gred_if.sv.
//
// Usage:
//   i_pix carries RGB pixel words in raster order; pad words follow each frame
//   (image_width + 1 of them) to flush the last results. o_res gives one word
//   per decided pixel: edge_res and frame_end on the last pixel of the frame.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
//   Throughput: one word per clock while o_res.ready is high. The line
//   memory is read when a word is accepted and written back when that
//   word leaves stage A; a read of the entry being written is forwarded.
//   The result for a pixel passes through stages A, B, C and the output
//   register after the word that decides it, which is the word one line plus one pixel later.
//   Reset: counters and neighbour registers clear, registers take their
//   defaults (640 x 480, threshold 20); no memory clearing pass.
//   Stall: the pipeline holds when o_res.ready is low; bubbles are squeezed
//   out, so i_pix.ready stays high until every stage holds a word.
module gray_roberts_edge_detect (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    gred_pix_if.sink                            i_pix,
    gred_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [gred_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gred_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW = gred_pkg::CNT_W;
    localparam int PW = gred_pkg::PIX_W;
    localparam int AW = gred_pkg::ADDR_W;

    // configuration
    logic [CW-1:0]               r_w;
    logic [CW-1:0]               r_h;
    logic [CW-1:0]               r_h1;
    logic [gred_pkg::THR2_W-1:0] r_thr2;

    // counters and neighbours
    logic [CW-1:0] r_col, r_row;
    logic [PW-1:0] r_left, r_ul;

    // line memory
    logic [PW-1:0] mem [gred_pkg::MAX_WIDTH];
    logic [PW-1:0] r_q;
    logic          r_fwd;
    logic [PW-1:0] r_fwd_d;

    // stage A
    logic          r_a_vld, r_a_emit, r_a_ge1, r_a_fend, r_a_wen;
    logic [CW-1:0] r_a_col;
    logic [PW-1:0] r_a_cur;
    // stage B
    logic                 r_b_vld, r_b_fend;
    logic signed [PW:0]   r_b_d1, r_b_d2;
    // stage C
    logic                 r_c_vld, r_c_fend;
    logic [2*PW-1:0]      r_c_sq1, r_c_sq2;
    // output
    logic           r_o_vld;
    gred_pkg::t_res r_o;

    logic en_a, en_b, en_c, en_o, acc, a_take;
    logic in_frame, emit, fend, wen, fwd_hit;
    logic [PW-1:0] cur, above, diag, right;
    logic [CW:0]   col_inc;
    logic [CW-1:0] n_col, n_row;
    logic signed [PW:0]   d1, d2;
    logic signed [2*PW+1:0] sq1, sq2;
    logic [2*PW:0]  mag;

    assign en_o   = !r_o_vld || o_res.ready;
    assign en_c   = !r_c_vld || en_o;
    assign en_b   = !r_b_vld || en_c;
    assign en_a   = !r_a_vld || en_b;
    assign acc    = i_pix.valid && en_a;
    assign a_take = r_a_vld && en_b;

    assign i_pix.ready = en_a;
    assign o_res.valid = r_o_vld;
    assign o_res.data  = r_o;

    // accept side
    always_comb begin
        in_frame = r_row < r_h;
        cur      = (!i_pix.data.pad && in_frame) ? gred_pkg::to_gray(i_pix.data) : '0;
        emit     = (r_row >= CW'(2)) || (r_row == CW'(1) && r_col != '0);
        fend     = r_row >= r_h1;
        wen      = r_col < CW'(gred_pkg::MAX_WIDTH);
        fwd_hit  = r_a_vld && r_a_wen && (r_a_col == r_col);
        col_inc  = {1'b0, r_col} + (CW+1)'(1);
        n_col    = r_col;
        n_row    = r_row;
        if (fend) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= {1'b0, r_w}) begin
            n_col = '0;
            n_row = r_row + CW'(1);
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    // inputs of stages B, C and the output: neighbours, differences, squares, sum
    always_comb begin
        above = !r_a_wen ? '0 : (r_fwd ? r_fwd_d : r_q);
        diag  = r_a_ge1 ? r_a_cur : '0;
        right = r_a_ge1 ? above : '0;
        d1    = $signed({1'b0, r_ul}) - $signed({1'b0, diag});
        d2    = $signed({1'b0, r_left}) - $signed({1'b0, right});
        sq1   = (2*PW+2)'(r_b_d1) * (2*PW+2)'(r_b_d1);
        sq2   = (2*PW+2)'(r_b_d2) * (2*PW+2)'(r_b_d2);
        mag   = {1'b0, r_c_sq1} + {1'b0, r_c_sq2};
    end

    always_ff @(posedge i_clk) begin
        if (a_take && r_a_wen) begin
            mem[r_a_col[AW-1:0]] <= r_a_cur;
        end
        if (acc) begin
            r_q <= mem[r_col[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= gred_pkg::WIDTH_RST;
            r_h     <= gred_pkg::HEIGHT_RST;
            r_h1    <= gred_pkg::HEIGHT_RST + CW'(1);
            r_thr2  <= gred_pkg::THR2_RST;
            r_col   <= '0;
            r_row   <= '0;
            r_left  <= '0;
            r_ul    <= '0;
            r_fwd   <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gred_pkg::REG_IMAGE_WIDTH: begin
                        r_w <= gred_pkg::clamp_dim(i_cfg_data, CW'(gred_pkg::MAX_WIDTH));
                    end
                    gred_pkg::REG_IMAGE_HEIGHT: begin
                        r_h  <= gred_pkg::clamp_dim(i_cfg_data, CW'(gred_pkg::HEIGHT_CAP));
                        r_h1 <= gred_pkg::clamp_dim(i_cfg_data, CW'(gred_pkg::HEIGHT_CAP))
                                + CW'(1);
                    end
                    gred_pkg::REG_EDGE_THRESHOLD: begin
                        r_thr2 <= {{gred_pkg::THR_W{1'b0}},
                                   i_cfg_data[gred_pkg::THR_W-1:0]}
                                  * {{gred_pkg::THR_W{1'b0}},
                                     i_cfg_data[gred_pkg::THR_W-1:0]};
                    end
                    default: begin
                    end
                endcase
            end
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (en_a) begin
                r_a_vld <= acc;
                r_fwd   <= acc && fwd_hit;
            end
            if (a_take) begin
                r_ul   <= above;
                r_left <= r_a_cur;
            end
            if (en_b) r_b_vld <= r_a_vld && r_a_emit;
            if (en_c) r_c_vld <= r_b_vld;
            if (en_o) r_o_vld <= r_c_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_cur  <= cur;
            r_a_col  <= r_col;
            r_a_wen  <= wen;
            r_a_emit <= emit;
            r_a_ge1  <= r_col != '0;
            r_a_fend <= fend;
            r_fwd_d  <= r_a_cur;
        end
        if (en_b) begin
            r_b_d1   <= d1;
            r_b_d2   <= d2;
            r_b_fend <= r_a_fend;
        end
        if (en_c) begin
            r_c_sq1  <= sq1[2*PW-1:0];
            r_c_sq2  <= sq2[2*PW-1:0];
            r_c_fend <= r_b_fend;
        end
        if (en_o) begin
            r_o.edge_res  <= {1'b0, mag} >= r_thr2;
            r_o.frame_end <= r_c_fend;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (r_row >= r_h1) |=> (r_col == '0) && (r_row == '0))
        else $error("counters did not wrap at frame end");

    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_a_vld)
        else $error("forward flag set with stage A empty");

    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !en_b |=> r_a_vld && $stable(r_a_col) && $stable(r_a_cur))
        else $error("stalled stage A word changed");

    a_fwd_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && fwd_hit |=> r_fwd && r_a_wen)
        else $error("same-entry read not forwarded");
`endif

endmodule
